@@ rtl/swc_pkg.sv @@
// ----------------------------------------------------------------------------
// Sphere wall collision package
// Register indexes, the pipeline item type and fixed-point helpers shared by
// the collision pipeline.
// ----------------------------------------------------------------------------
package swc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_RADIUS      = 2'd0;
  localparam logic [1:0] REG_RESTITUTION = 2'd1;
  localparam logic [1:0] REG_FRICTION    = 2'd2;

  // Coefficient value of one in Q1.16.
  localparam logic [16:0] Q_ONE = 17'h10000;

  // Normal vectors are Q2.30.
  localparam int N_SHIFT = 30;

  // Pipeline stage map.
  localparam int ST_SQUARE   = 0;
  localparam int ST_SUM      = 1;
  localparam int ST_SQRT_LO  = 2;
  localparam int ST_SQRT_HI  = 33;
  localparam int ST_DIV_INIT = 34;
  localparam int ST_DIV_LO   = 35;
  localparam int ST_DIV_HI   = 64;
  localparam int ST_NORMAL   = 65;
  localparam int ST_PROD     = 66;
  localparam int ST_DOT      = 67;
  localparam int ST_VN       = 68;
  localparam int ST_VNN      = 69;
  localparam int ST_TAN      = 70;
  localparam int ST_SCALE    = 71;
  localparam int ST_OUT      = 72;
  localparam int NUM_STAGES  = 73;

  // One particle as it travels down the pipeline.
  typedef struct packed {
    logic              last;
    logic              clamped;
    logic              outward;
    logic [2:0][31:0]  p;
    logic [2:0][31:0]  v;
    logic [2:0][62:0]  sq;
    logic [61:0]       rr;
    logic [63:0]       s;
    logic [33:0]       srem;
    logic [31:0]       root;
    logic [2:0][32:0]  drem;
    logic [2:0][30:0]  q;
    logic [2:0][31:0]  n;
    logic [2:0][62:0]  pr;
    logic [2:0][63:0]  vp;
    logic [2:0][31:0]  po;
    logic [63:0]       vnf;
    logic [33:0]       vn;
    logic [2:0][65:0]  vnn;
    logic [2:0][35:0]  vnorm;
    logic [2:0][35:0]  vtan;
    logic [2:0][53:0]  ta;
    logic [2:0][53:0]  tb;
  } item_t;

  // Arithmetic shift right that rounds toward zero.
  function automatic logic signed [65:0] shr_tz(input logic signed [65:0] val,
                                                input int sh);
    logic [65:0] mag;
    logic [65:0] res;
    mag = val[65] ? 66'(-val) : 66'(val);
    res = mag >> sh;
    return val[65] ? $signed(66'(-res)) : $signed(res);
  endfunction

  // Saturate to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [65:0] val);
    if (val > 66'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (val < -66'sd2147483648) begin
      return 32'h8000_0000;
    end
    return val[31:0];
  endfunction

endpackage

@@ rtl/sphere_wall_collision.sv @@
// ----------------------------------------------------------------------------
// Sphere wall collision
// Projects a particle that lies on or beyond a spherical boundary back onto
// it and reflects its outward velocity with restitution and friction.
// ----------------------------------------------------------------------------
// The block takes one particle per clock and returns one per clock. The
// length of the pipeline is set by the square root of the squared distance
// (32 stages, one root bit each) followed by the three normal divisions (31
// stages, one quotient bit each, in three lanes). The whole pipeline holds
// when the output transaction is stalled. The user must write configuration
// only while no particle is in flight; the block itself does not enforce it.
module sphere_wall_collision (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata,
  // Input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: pos_in_x, pos_in_y, pos_in_z, vel_in_x, vel_in_y, vel_in_z
  input  logic [191:0] in_tdata,
  input  logic         in_tlast,   // last_particle
  // Result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: pos_out_x, pos_out_y, pos_out_z, vel_out_x, vel_out_y, vel_out_z
  output logic [191:0] out_tdata,
  output logic         out_tuser,  // was_clamped
  output logic         out_tlast   // last_particle_out
);
  import swc_pkg::*;

  logic [30:0] radius_r;
  logic [16:0] rest_r;
  logic [16:0] fric_r;
  logic [16:0] coef_e;
  logic [16:0] coef_d;
  logic        adv;

  item_t stg_r   [NUM_STAGES];
  item_t stg_nxt [NUM_STAGES];
  logic  [NUM_STAGES-1:0] vld_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      rest_r   <= '0;
      fric_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RADIUS:      radius_r <= cfg_wdata;
        REG_RESTITUTION: rest_r   <= cfg_wdata[16:0];
        REG_FRICTION:    fric_r   <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  // Coefficients above one are treated as one.
  assign coef_e = (rest_r > Q_ONE) ? Q_ONE : rest_r;
  assign coef_d = Q_ONE - ((fric_r > Q_ONE) ? Q_ONE : fric_r);

  // The pipeline moves whenever the output stage is empty or being taken.
  assign adv       = !vld_r[NUM_STAGES-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_tvalid};
    end
  end

  // Stage logic.
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    if (k == ST_SQUARE) begin : g_square
      // Capture the particle and square each coordinate magnitude.
      always_comb begin
        logic [31:0] m;
        stg_nxt[k]      = '0;
        stg_nxt[k].last = in_tlast;
        for (int i = 0; i < 3; i++) begin
          stg_nxt[k].p[i] = in_tdata[32*i +: 32];
          stg_nxt[k].v[i] = in_tdata[96 + 32*i +: 32];
          m = in_tdata[32*i+31] ? 32'(-in_tdata[32*i +: 32]) : in_tdata[32*i +: 32];
          stg_nxt[k].sq[i] = 63'({32'd0, m} * {32'd0, m});
        end
        stg_nxt[k].rr = 62'({31'd0, radius_r} * {31'd0, radius_r});
      end
    end else if (k == ST_SUM) begin : g_sum
      // Squared distance and the boundary test.
      always_comb begin
        stg_nxt[k]         = stg_r[k-1];
        stg_nxt[k].s       = 64'(stg_r[k-1].sq[0]) + 64'(stg_r[k-1].sq[1])
                             + 64'(stg_r[k-1].sq[2]);
        stg_nxt[k].clamped = stg_nxt[k].s >= 64'(stg_r[k-1].rr);
        stg_nxt[k].srem    = '0;
        stg_nxt[k].root    = '0;
      end
    end else if (k >= ST_SQRT_LO && k <= ST_SQRT_HI) begin : g_sqrt
      // One root bit per stage, most significant pair of radicand bits first.
      localparam int B = ST_SQRT_HI - k;
      always_comb begin
        logic [35:0] t;
        logic [35:0] trial;
        stg_nxt[k] = stg_r[k-1];
        t     = {stg_r[k-1].srem, stg_r[k-1].s[2*B+1 -: 2]};
        trial = {2'b00, stg_r[k-1].root, 2'b01};
        if (t >= trial) begin
          stg_nxt[k].srem = 34'(t - trial);
          stg_nxt[k].root = {stg_r[k-1].root[30:0], 1'b1};
        end else begin
          stg_nxt[k].srem = t[33:0];
          stg_nxt[k].root = {stg_r[k-1].root[30:0], 1'b0};
        end
      end
    end else if (k == ST_DIV_INIT) begin : g_div_init
      // A coordinate magnitude never exceeds the length, so the top quotient
      // bit is set only when the two are equal.
      always_comb begin
        logic [31:0] m;
        stg_nxt[k] = stg_r[k-1];
        for (int i = 0; i < 3; i++) begin
          m = stg_r[k-1].p[i][31] ? 32'(-stg_r[k-1].p[i]) : stg_r[k-1].p[i];
          if (m == stg_r[k-1].root) begin
            stg_nxt[k].q[i]    = 31'h4000_0000;
            stg_nxt[k].drem[i] = '0;
          end else begin
            stg_nxt[k].q[i]    = '0;
            stg_nxt[k].drem[i] = {1'b0, m};
          end
        end
      end
    end else if (k >= ST_DIV_LO && k <= ST_DIV_HI) begin : g_div
      // Restoring division, one quotient bit per stage in each lane.
      localparam int B = ST_DIV_HI - k;
      always_comb begin
        logic [32:0] t;
        stg_nxt[k] = stg_r[k-1];
        for (int i = 0; i < 3; i++) begin
          t = {stg_r[k-1].drem[i][31:0], 1'b0};
          if (t >= {1'b0, stg_r[k-1].root}) begin
            stg_nxt[k].drem[i] = t - {1'b0, stg_r[k-1].root};
            stg_nxt[k].q[i][B] = 1'b1;
          end else begin
            stg_nxt[k].drem[i] = t;
          end
        end
      end
    end else if (k == ST_NORMAL) begin : g_normal
      // Signed unit normal; a zero length gives a zero normal.
      always_comb begin
        stg_nxt[k] = stg_r[k-1];
        for (int i = 0; i < 3; i++) begin
          if (stg_r[k-1].root == '0) begin
            stg_nxt[k].n[i] = '0;
          end else if (stg_r[k-1].p[i][31]) begin
            stg_nxt[k].n[i] = 32'(-{1'b0, stg_r[k-1].q[i]});
          end else begin
            stg_nxt[k].n[i] = {1'b0, stg_r[k-1].q[i]};
          end
        end
      end
    end else if (k == ST_PROD) begin : g_prod
      // Projected position and velocity-normal products.
      always_comb begin
        stg_nxt[k] = stg_r[k-1];
        for (int i = 0; i < 3; i++) begin
          stg_nxt[k].pr[i] = 63'($signed({1'b0, radius_r}) * $signed(stg_r[k-1].n[i]));
          stg_nxt[k].vp[i] = 64'($signed(stg_r[k-1].v[i]) * $signed(stg_r[k-1].n[i]));
        end
      end
    end else if (k == ST_DOT) begin : g_dot
      // Normal velocity and the new position.
      always_comb begin
        logic signed [65:0] sh;
        stg_nxt[k]     = stg_r[k-1];
        stg_nxt[k].vnf = stg_r[k-1].vp[0] + stg_r[k-1].vp[1] + stg_r[k-1].vp[2];
        stg_nxt[k].outward = stg_r[k-1].clamped && ($signed(stg_nxt[k].vnf) > 64'sd0);
        for (int i = 0; i < 3; i++) begin
          sh = shr_tz(66'($signed(stg_r[k-1].pr[i])), N_SHIFT);
          stg_nxt[k].po[i] = stg_r[k-1].clamped ? sh[31:0] : stg_r[k-1].p[i];
        end
      end
    end else if (k == ST_VN) begin : g_vn
      always_comb begin
        logic signed [65:0] sh;
        stg_nxt[k]    = stg_r[k-1];
        sh            = shr_tz(66'($signed(stg_r[k-1].vnf)), N_SHIFT);
        stg_nxt[k].vn = sh[33:0];
      end
    end else if (k == ST_VNN) begin : g_vnn
      // Normal velocity vector before scaling.
      always_comb begin
        stg_nxt[k] = stg_r[k-1];
        for (int i = 0; i < 3; i++) begin
          stg_nxt[k].vnn[i] = 66'($signed(stg_r[k-1].vn) * $signed(stg_r[k-1].n[i]));
        end
      end
    end else if (k == ST_TAN) begin : g_tan
      // Split velocity into normal and tangential parts.
      always_comb begin
        logic signed [65:0] sh;
        stg_nxt[k] = stg_r[k-1];
        for (int i = 0; i < 3; i++) begin
          sh = shr_tz($signed(stg_r[k-1].vnn[i]), N_SHIFT);
          stg_nxt[k].vnorm[i] = sh[35:0];
          stg_nxt[k].vtan[i]  = 36'(36'($signed(stg_r[k-1].v[i])) - sh[35:0]);
        end
      end
    end else if (k == ST_SCALE) begin : g_scale
      // Friction damping and restitution products.
      always_comb begin
        stg_nxt[k] = stg_r[k-1];
        for (int i = 0; i < 3; i++) begin
          stg_nxt[k].ta[i] = 54'($signed({1'b0, coef_d}) * $signed(stg_r[k-1].vtan[i]));
          stg_nxt[k].tb[i] = 54'($signed({1'b0, coef_e}) * $signed(stg_r[k-1].vnorm[i]));
        end
      end
    end else if (k == ST_OUT) begin : g_out
      // Combine, scale back and saturate; keep the velocity when not outward.
      always_comb begin
        logic signed [65:0] acc;
        stg_nxt[k] = stg_r[k-1];
        for (int i = 0; i < 3; i++) begin
          acc = 66'($signed(stg_r[k-1].ta[i])) - 66'($signed(stg_r[k-1].tb[i]));
          if (stg_r[k-1].outward) begin
            stg_nxt[k].v[i] = sat32(shr_tz(acc, 16));
          end
        end
      end
    end

    // Stage register.
    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  // Result stream.
  assign out_tvalid = vld_r[NUM_STAGES-1];
  assign out_tdata  = {stg_r[NUM_STAGES-1].v[2], stg_r[NUM_STAGES-1].v[1],
                       stg_r[NUM_STAGES-1].v[0], stg_r[NUM_STAGES-1].po[2],
                       stg_r[NUM_STAGES-1].po[1], stg_r[NUM_STAGES-1].po[0]};
  assign out_tuser  = stg_r[NUM_STAGES-1].clamped;
  assign out_tlast  = stg_r[NUM_STAGES-1].last;

endmodule
